/* design/group_ordered_queue_unit_assert.svh */
// Assertion macros for the group ordered queue.
`ifndef GROUP_ORDERED_QUEUE_UNIT_ASSERT_SVH
`define GROUP_ORDERED_QUEUE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GOQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GOQ_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GOQ_ASSERT(lbl, prop, msg)
`define GOQ_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

/* design/goq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package goq_pkg;

    localparam int ID_W             = 10;
    localparam int GID_W            = 10;
    localparam int ELEMENT_SLOTS_DEF = 1024;
    localparam int GROUP_SLOTS_DEF   = 1024;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STS_IGNORED = 2'd0,
        STS_PUSHED  = 2'd1,
        STS_POPPED  = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_LINK,
        S_SPLICE,
        S_SELF,
        S_POP_A,
        S_POP_B,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* design/group_ordered_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Signals                                       Direction
// in       i_in_valid, o_in_stall, i_kind,
//          i_element_id, i_group_id                      upstream -> unit
// out      o_out_valid, i_out_stall, o_status,
//          o_popped_id                                   unit -> downstream
//
// One item at a time; links and group fronts in an element RAM and a group RAM
// (registered read), queue head and tail in registers.
// Path to result: pop via POP_A, POP_B; push to tail via LOOK, LINK; push into a
// group via LOOK, LINK, SPLICE, SELF; empty pop or out-of-range push from IDLE;
// duplicate push from LOOK. After reset a clearing pass runs with o_in_stall high.
// A stalled result holds the unit after the next item.

`include "group_ordered_queue_unit_assert.svh"

module group_ordered_queue_unit
    import goq_pkg::*;
#(
    parameter int ELEMENT_SLOTS = ELEMENT_SLOTS_DEF,
    parameter int GROUP_SLOTS   = GROUP_SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_kind,
    input  wire logic [ID_W-1:0]  i_element_id,
    input  wire logic [GID_W-1:0] i_group_id,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [1:0]            o_status,
    output logic [ID_W-1:0]       o_popped_id
);

    localparam int EAW  = $clog2(ELEMENT_SLOTS);
    localparam int GAW  = $clog2(GROUP_SLOTS);
    localparam int MAXS = (ELEMENT_SLOTS > GROUP_SLOTS) ? ELEMENT_SLOTS : GROUP_SLOTS;
    localparam int CW   = $clog2(MAXS);

    typedef struct packed {
        logic           queued;
        logic [GAW-1:0] grp;
        logic [EAW-1:0] prev;
        logic [EAW-1:0] next;
    } t_elem;

    typedef struct packed {
        logic           valid;
        logic [EAW-1:0] front;
    } t_gfront;

    t_elem   r_emem [ELEMENT_SLOTS];
    t_gfront r_gmem [GROUP_SLOTS];
    t_elem   r_erd;
    t_gfront r_grd;

    logic           e_we;
    logic [EAW-1:0] e_waddr;
    t_elem          e_wdata;
    logic [EAW-1:0] e_raddr;
    logic           g_we;
    logic [GAW-1:0] g_waddr;
    t_gfront        g_wdata;
    logic [GAW-1:0] g_raddr;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_clr_cnt, n_clr_cnt;
    logic [EAW-1:0] r_head, n_head;
    logic [EAW-1:0] r_tail, n_tail;
    logic [EAW-1:0] r_elem, n_elem;
    logic [GAW-1:0] r_grp, n_grp;
    logic           r_front_case, n_front_case;
    logic [EAW-1:0] r_nbr, n_nbr;
    logic [EAW-1:0] r_before, n_before;
    logic [EAW-1:0] r_after, n_after;
    logic [GAW-1:0] r_pgrp, n_pgrp;
    t_status        r_sts, n_sts;
    logic [ID_W-1:0] r_res_id, n_res_id;
    logic           r_out_valid, n_out_valid;
    t_status        r_out_status, n_out_status;
    logic [ID_W-1:0] r_out_popped, n_out_popped;

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_emem[e_waddr] <= e_wdata;
        end
        r_erd <= r_emem[e_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_gmem[g_waddr] <= g_wdata;
        end
        r_grd <= r_gmem[g_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem       <= n_elem;
        r_grp        <= n_grp;
        r_front_case <= n_front_case;
        r_nbr        <= n_nbr;
        r_before     <= n_before;
        r_after      <= n_after;
        r_pgrp       <= n_pgrp;
        r_sts        <= n_sts;
        r_res_id     <= n_res_id;
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
    end

    always_comb begin
        logic            out_free;
        logic            push_ok;
        logic            res_load;
        t_status         res_sts;
        logic [ID_W-1:0] res_id;
        t_elem           w;

        out_free = !r_out_valid || !i_out_stall;
        push_ok  = (i_element_id != '0)
                && (32'(i_element_id) < 32'(ELEMENT_SLOTS))
                && (32'(i_group_id) < 32'(GROUP_SLOTS));
        res_load = 1'b0;
        res_sts  = STS_IGNORED;
        res_id   = '0;
        w        = r_erd;

        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_head       = r_head;
        n_tail       = r_tail;
        n_elem       = r_elem;
        n_grp        = r_grp;
        n_front_case = r_front_case;
        n_nbr        = r_nbr;
        n_before     = r_before;
        n_after      = r_after;
        n_pgrp       = r_pgrp;
        n_sts        = r_sts;
        n_res_id     = r_res_id;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;

        e_we    = 1'b0;
        e_waddr = '0;
        e_wdata = '0;
        e_raddr = '0;
        g_we    = 1'b0;
        g_waddr = '0;
        g_wdata = '0;
        g_raddr = '0;

        case (r_state)
            S_CLEAR: begin
                e_we      = 32'(r_clr_cnt) < 32'(ELEMENT_SLOTS);
                e_waddr   = EAW'(r_clr_cnt);
                g_we      = 32'(r_clr_cnt) < 32'(GROUP_SLOTS);
                g_waddr   = GAW'(r_clr_cnt);
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CW'(MAXS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_POP) begin
                        if (r_head == '0) begin
                            res_load = 1'b1;
                            res_sts  = STS_EMPTY;
                        end else begin
                            e_raddr = r_head;
                            n_state = S_POP_A;
                        end
                    end else if (!push_ok) begin
                        res_load = 1'b1;
                        res_sts  = STS_IGNORED;
                    end else begin
                        e_raddr = EAW'(i_element_id);
                        g_raddr = GAW'(i_group_id);
                        n_elem  = EAW'(i_element_id);
                        n_grp   = GAW'(i_group_id);
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (r_erd.queued) begin
                    res_load = 1'b1;
                    res_sts  = STS_IGNORED;
                end else begin
                    g_we    = 1'b1;
                    g_waddr = r_grp;
                    g_wdata = '{valid: 1'b1, front: r_elem};
                    n_state = S_LINK;
                    if (r_grd.valid) begin
                        n_front_case = 1'b1;
                        n_nbr        = r_grd.front;
                        e_raddr      = r_grd.front;
                    end else begin
                        n_front_case = 1'b0;
                        n_nbr        = r_tail;
                        e_raddr      = r_tail;
                        e_we         = 1'b1;
                        e_waddr      = r_elem;
                        e_wdata      = '{queued: 1'b1, grp: r_grp, prev: r_tail, next: '0};
                        n_tail       = r_elem;
                    end
                end
            end
            S_LINK: begin
                if (r_front_case) begin
                    w.prev   = r_elem;
                    e_we     = 1'b1;
                    e_waddr  = r_nbr;
                    e_wdata  = w;
                    e_raddr  = r_erd.prev;
                    n_before = r_erd.prev;
                    n_state  = S_SPLICE;
                end else begin
                    if (r_nbr != '0) begin
                        w.next  = r_elem;
                        e_we    = 1'b1;
                        e_waddr = r_nbr;
                        e_wdata = w;
                    end else begin
                        n_head = r_elem;
                    end
                    res_load = 1'b1;
                    res_sts  = STS_PUSHED;
                end
            end
            S_SPLICE: begin
                if (r_before != '0) begin
                    w.next  = r_elem;
                    e_we    = 1'b1;
                    e_waddr = r_before;
                    e_wdata = w;
                end else begin
                    n_head = r_elem;
                end
                n_state = S_SELF;
            end
            S_SELF: begin
                e_we     = 1'b1;
                e_waddr  = r_elem;
                e_wdata  = '{queued: 1'b1, grp: r_grp, prev: r_before, next: r_nbr};
                res_load = 1'b1;
                res_sts  = STS_PUSHED;
            end
            S_POP_A: begin
                w.queued = 1'b0;
                e_we     = 1'b1;
                e_waddr  = r_head;
                e_wdata  = w;
                e_raddr  = r_erd.next;
                n_after  = r_erd.next;
                n_pgrp   = r_erd.grp;
                n_state  = S_POP_B;
            end
            S_POP_B: begin
                g_we    = 1'b1;
                g_waddr = r_pgrp;
                if (r_after != '0 && r_erd.grp == r_pgrp) begin
                    g_wdata = '{valid: 1'b1, front: r_after};
                end
                if (r_after != '0) begin
                    w.prev  = '0;
                    e_we    = 1'b1;
                    e_waddr = r_after;
                    e_wdata = w;
                end
                n_head = r_after;
                if (r_tail == r_head) begin
                    n_tail = '0;
                end
                res_load = 1'b1;
                res_sts  = STS_POPPED;
                res_id   = ID_W'(r_head);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_sts;
                    n_out_popped = r_res_id;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_load) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = res_sts;
                n_out_popped = res_id;
                n_state      = S_IDLE;
            end else begin
                n_sts    = res_sts;
                n_res_id = res_id;
                n_state  = S_DONE;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_popped_id = r_out_popped;

    `GOQ_ASSERT_ANY(a_reset_clears, !i_rst_n |=> (r_state == S_CLEAR), "no clear pass")
    `GOQ_ASSERT(a_clear_empty, (r_state == S_CLEAR) |-> ({r_head, r_tail} == '0), "busy clear")
    `GOQ_ASSERT(a_head_tail, (r_state == S_IDLE && r_head == '0) |-> (r_tail == '0), "stray tail")
    `GOQ_ASSERT(a_no_rw_clash, (e_we && r_state != S_CLEAR) |-> (e_waddr != e_raddr), "RAM clash")
    `GOQ_ASSERT(a_pop_id, (r_out_valid && r_out_status == STS_POPPED) |-> (r_out_popped != '0),
        "pop returned the sentinel")

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import goq_pkg::*;

    localparam int ELEM_N      = ELEMENT_SLOTS_DEF;
    localparam int GROUP_N     = GROUP_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1100;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    popped_id;
    } t_queue_result;

    typedef struct {
        t_kind              kind;
        logic [ID_W-1:0]    element_id;
        logic [GID_W-1:0]   group_id;
        bit                 typed;
        t_status            status;
        logic [ID_W-1:0]    popped_id;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [ID_W-1:0]    i_element_id;
    logic [GID_W-1:0]   i_group_id;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [ID_W-1:0]    o_popped_id;

    group_ordered_queue_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_element_id (i_element_id),
        .i_group_id   (i_group_id),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_popped_id  (o_popped_id)
    );

    // Mirror of the queue: doubly linked list headed by sentinel slot 0.
    logic [ID_W-1:0]    link_next [ELEM_N];
    logic [ID_W-1:0]    link_prev [ELEM_N];
    logic [GID_W-1:0]   elem_group [ELEM_N];
    bit                 elem_queued [ELEM_N];
    bit                 front_valid [GROUP_N];
    logic [ID_W-1:0]    front_elem [GROUP_N];
    logic [ID_W-1:0]    tail_elem;

    t_queue_result      pending_results [$];
    t_directed_row      directed_rows [$];
    int unsigned        items_sent;
    int unsigned        error_count;
    int unsigned        idle_cycles;
    bit                 calm_phase;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_queue_mirror();
        for (int i = 0; i < ELEM_N; i++) begin
            link_next[i]   = '0;
            link_prev[i]   = '0;
            elem_group[i]  = '0;
            elem_queued[i] = 1'b0;
        end
        for (int i = 0; i < GROUP_N; i++) begin
            front_valid[i] = 1'b0;
            front_elem[i]  = '0;
        end
        tail_elem = '0;
    endfunction

    function automatic t_queue_result apply_queue_op(t_kind kind, logic [ID_W-1:0] elem,
                                                     logic [GID_W-1:0] grp);
        t_queue_result      res;
        logic [ID_W-1:0]    head;
        logic [ID_W-1:0]    succ;
        logic [ID_W-1:0]    pred;
        logic [GID_W-1:0]   head_grp;
        res.status    = STS_IGNORED;
        res.popped_id = '0;
        if (kind == KIND_PUSH) begin
            if (elem == 0 || elem >= ELEM_N || grp >= GROUP_N || elem_queued[elem])
                return res;
            elem_queued[elem] = 1'b1;
            elem_group[elem]  = grp;
            if (front_valid[grp]) begin
                head = front_elem[grp];
                pred = link_prev[head];
                link_next[pred] = elem;
                link_prev[elem] = pred;
                link_next[elem] = head;
                link_prev[head] = elem;
            end else begin
                link_next[tail_elem] = elem;
                link_prev[elem]      = tail_elem;
                link_next[elem]      = '0;
                tail_elem            = elem;
            end
            front_valid[grp] = 1'b1;
            front_elem[grp]  = elem;
            res.status = STS_PUSHED;
        end else begin
            head = link_next[0];
            if (head == 0) begin
                res.status = STS_EMPTY;
                return res;
            end
            succ     = link_next[head];
            head_grp = elem_group[head];
            if (succ != 0 && elem_group[succ] == head_grp) begin
                front_valid[head_grp] = 1'b1;
                front_elem[head_grp]  = succ;
            end else begin
                front_valid[head_grp] = 1'b0;
            end
            link_next[0] = succ;
            if (succ != 0)
                link_prev[succ] = '0;
            if (tail_elem == head)
                tail_elem = '0;
            elem_queued[head] = 1'b0;
            res.status    = STS_POPPED;
            res.popped_id = head;
        end
        return res;
    endfunction

    task automatic send_item(t_kind kind, logic [ID_W-1:0] elem, logic [GID_W-1:0] grp,
                             bit typed, t_status status, logic [ID_W-1:0] popped);
        int unsigned    gap;
        t_queue_result  res;
        gap = calm_phase ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_element_id <= elem;
        i_group_id   <= grp;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        res = apply_queue_op(kind, elem, grp);
        if (typed) begin
            res.status    = status;
            res.popped_id = popped;
        end
        pending_results.push_back(res);
        items_sent++;
        calm_phase = (items_sent % 250) >= 180;
    endtask

    task automatic send_random_item();
        int unsigned        r;
        t_kind              kind;
        logic [ID_W-1:0]    elem;
        logic [GID_W-1:0]   grp;
        r = $urandom_range(0, 99);
        kind = (r < 45) ? KIND_POP : KIND_PUSH;
        r = $urandom_range(0, 99);
        if (r < 85)
            elem = ID_W'($urandom_range(1, 40));
        else if (r < 95)
            elem = ID_W'($urandom_range(0, ELEM_N - 1));
        else
            elem = (r < 97) ? '0 : '1;
        r = $urandom_range(0, 99);
        if (r < 70)
            grp = GID_W'($urandom_range(0, 5));
        else if (r < 90)
            grp = GID_W'($urandom_range(0, GROUP_N - 1));
        else
            grp = '1;
        send_item(kind, elem, grp, 1'b0, STS_IGNORED, '0);
    endtask

    initial begin
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b1, STS_EMPTY,   10'd0});
        directed_rows.push_back('{KIND_POP,  10'd1023, 10'd1023, 1'b1, STS_EMPTY,   10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'd0,    10'd5,    1'b1, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'd1023, 10'd1023, 1'b1, STS_PUSHED,  10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'd1023, 10'd0,    1'b1, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'd1,    10'd0,    1'b1, STS_PUSHED,  10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'd2,    10'd1023, 1'b1, STS_PUSHED,  10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'd3,    10'd0,    1'b1, STS_PUSHED,  10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'h2AA,  10'h155,  1'b1, STS_PUSHED,  10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'h155,  10'h2AA,  1'b1, STS_PUSHED,  10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'h155,  10'h155,  1'b1, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        // regroup: 2 comes back under group 0
        directed_rows.push_back('{KIND_PUSH, 10'd2,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_PUSH, 10'd1023, 10'd5,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b0, STS_IGNORED, 10'd0});
        directed_rows.push_back('{KIND_POP,  10'd0,    10'd0,    1'b1, STS_EMPTY,   10'd0});

        clear_queue_mirror();
        items_sent   = 0;
        error_count  = 0;
        calm_phase   = 1'b0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_kind       <= KIND_PUSH;
        i_element_id <= '0;
        i_group_id   <= '0;
        i_out_stall  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].element_id,
                      directed_rows[i].group_id, directed_rows[i].typed,
                      directed_rows[i].status, directed_rows[i].popped_id);
        repeat (RANDOM_ITEMS) send_random_item();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("group_ordered_queue_unit regression: pass");
        else
            $display("group_ordered_queue_unit regression: fail");
        $finish;
    end

    initial begin : result_sink
        int unsigned    hold;
        t_queue_result  want;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = calm_phase ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $error("o_status: result with no item pending, got %0d", o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("o_status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_popped_id !== want.popped_id) begin
                    $error("o_popped_id: expected %0d, got %0d", want.popped_id, o_popped_id);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("group_ordered_queue_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
